### hw/rtl/multichannel_volume_fader_defines.svh
// Assertion macros shared by the fader checker.
// No dependencies; included by bare file name.
`ifndef MULTICHANNEL_VOLUME_FADER_DEFINES_SVH
`define MULTICHANNEL_VOLUME_FADER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MCVF_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fader check failed");

// next-cycle implication, disabled in reset
`define MCVF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fader check failed");

`endif

### hw/rtl/mcvf_pkg.sv
// Types and constants of the multichannel volume fader.
// No dependencies; used by the top level and its checker.
package mcvf_pkg;

    localparam int CHANNELS_DEF = 8;
    localparam int LEN_W        = 17;
    localparam int PROD_W       = 24;
    localparam int LVL_W        = 7;
    localparam int MS_PER_UNIT  = 100;
    localparam logic [LEN_W-1:0] LEN_MAX    = 17'd131071;
    localparam logic [LVL_W-1:0] FULL_LEVEL = 7'd100;

    localparam logic [2:0] REQ_PLAY     = 3'd0;
    localparam logic [2:0] REQ_STOP     = 3'd1;
    localparam logic [2:0] REQ_SET_VOL  = 3'd2;
    localparam logic [2:0] REQ_TICK     = 3'd3;
    localparam logic [2:0] REQ_STOP_ALL = 3'd4;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [2:0]  channel;
        logic        loop_flag;
        logic        wait_flag;
        logic [9:0]  fade_units;
        logic [6:0]  volume;
        logic [9:0]  elapsed_ms;
    } t_req;

    typedef struct packed {
        logic [2:0]  out_channel;
        logic        apply_volume;
        logic [6:0]  level;
        logic        start_play;
        logic        halt;
        logic        repeat_res;
        logic        wait_end;
        logic        last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_DIV,
        S_FIN,
        S_ALL
    } t_state;

endpackage

### hw/rtl/multichannel_volume_fader.sv
// Multichannel volume fader: per-channel linear fades, player commands out.
// Depends on mcvf_pkg.
//
// One request beat is taken when start is high and busy is low. Play, set
// volume, a stop with no fade to interrupt, and ignored requests are handled
// in the accept cycle; their command (if any) is registered and shows on
// o_res with o_valid in the next cycle. Stop all emits one command per
// channel, one per cycle. A tick walks the channels in order: an idle
// channel is only scanned, a fading channel goes through scan, multiply, 24
// restoring division steps one quotient bit per cycle, and finish. A stop
// that interrupts a running fade goes through multiply, division and finish
// and emits no command. Results cannot be held off: each command is valid
// for exactly one cycle and must be taken then. No clearing pass after
// reset.
module multichannel_volume_fader #(
    parameter int CHANNELS = mcvf_pkg::CHANNELS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  mcvf_pkg::t_req i_req,
    output logic           o_valid,
    output mcvf_pkg::t_res o_res
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LW = mcvf_pkg::LEN_W;
    localparam int PW = mcvf_pkg::PROD_W;
    localparam int VW = mcvf_pkg::LVL_W;
    localparam logic [CW-1:0] IDX_LAST = CW'(CHANNELS - 1);

    // per-channel fade state
    logic [LW-1:0] r_len_a [CHANNELS];
    logic [LW-1:0] r_el_a  [CHANNELS];
    logic [VW-1:0] r_sl_a  [CHANNELS];
    logic [VW-1:0] r_tl_a  [CHANNELS];
    logic [LW-1:0] n_len_a [CHANNELS];
    logic [LW-1:0] n_el_a  [CHANNELS];
    logic [VW-1:0] n_sl_a  [CHANNELS];
    logic [VW-1:0] n_tl_a  [CHANNELS];

    mcvf_pkg::t_state r_state, n_state;
    logic [2:0]    r_op, n_op;
    logic [CW-1:0] r_idx, n_idx;
    logic [4:0]    r_cnt, n_cnt;
    logic [LW-1:0] r_rem, n_rem;
    logic [PW-1:0] r_dvd, n_dvd;
    logic [VW-1:0] r_q, n_q;
    logic          r_neg, n_neg;
    logic [LW-1:0] r_c, n_c;          // elapsed used for interpolation
    logic [LW-1:0] r_len, n_len;      // divisor
    logic [LW-1:0] r_newlen, n_newlen;
    logic [9:0]    r_dt, n_dt;
    logic          r_end, n_end;      // fade reaches its length this tick
    logic          r_valid, n_valid;
    mcvf_pkg::t_res r_res, n_res;

    logic          accept;
    logic          ch_ok;
    logic [CW-1:0] ch_idx;
    logic [LW-1:0] req_len;
    logic [VW-1:0] req_vol;
    logic          stop_interp;
    logic          idx_last;
    logic          more_fading;
    logic [LW:0]   el_sum;
    logic [LW-1:0] el_sat;
    logic signed [VW:0] diff;
    logic [LW:0]   rem_sh;
    logic signed [VW+1:0] lvl_s;
    logic [VW-1:0] lvl;

    assign busy     = (r_state != mcvf_pkg::S_IDLE);
    assign accept   = start && !busy;
    assign ch_ok    = (32'(i_req.channel) < CHANNELS);
    assign ch_idx   = CW'(i_req.channel);
    assign req_len  = LW'({7'b0, i_req.fade_units} * LW'(mcvf_pkg::MS_PER_UNIT));
    assign req_vol  = (i_req.volume > mcvf_pkg::FULL_LEVEL) ? mcvf_pkg::FULL_LEVEL
                                                            : i_req.volume;
    assign idx_last = (r_idx == IDX_LAST);
    // stop into a running fade starts from the interpolated level
    assign stop_interp = ch_ok && (i_req.fade_units != 10'd0)
                         && (r_len_a[ch_idx] != '0)
                         && (r_el_a[ch_idx] < r_len_a[ch_idx]);

    // any later channel still fading decides the last flag of a tick
    always_comb begin
        more_fading = 1'b0;
        for (int j = 0; j < CHANNELS; j++) begin
            if ((CW'(j) > r_idx) && (r_len_a[j] != '0)) begin
                more_fading = 1'b1;
            end
        end
    end

    assign el_sum = {1'b0, r_el_a[r_idx]} + (LW + 1)'(r_dt);
    assign el_sat = (el_sum > {1'b0, mcvf_pkg::LEN_MAX}) ? mcvf_pkg::LEN_MAX
                                                         : el_sum[LW-1:0];
    assign diff   = $signed({1'b0, r_tl_a[r_idx]}) - $signed({1'b0, r_sl_a[r_idx]});
    assign rem_sh = {r_rem, r_dvd[PW-1]};

    // start +/- quotient, clamped to 0..100
    always_comb begin
        if (r_neg) begin
            lvl_s = $signed({2'b0, r_sl_a[r_idx]}) - $signed({2'b0, r_q});
        end else begin
            lvl_s = $signed({2'b0, r_sl_a[r_idx]}) + $signed({2'b0, r_q});
        end
        if (lvl_s < 0) begin
            lvl = '0;
        end else if (lvl_s > $signed({2'b0, mcvf_pkg::FULL_LEVEL})) begin
            lvl = mcvf_pkg::FULL_LEVEL;
        end else begin
            lvl = lvl_s[VW-1:0];
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mcvf_pkg::S_IDLE: begin
                if (accept) begin
                    case (i_req.req_type)
                        mcvf_pkg::REQ_STOP:     if (stop_interp) n_state = mcvf_pkg::S_MUL;
                        mcvf_pkg::REQ_TICK:     n_state = mcvf_pkg::S_SCAN;
                        mcvf_pkg::REQ_STOP_ALL: n_state = mcvf_pkg::S_ALL;
                        default:                n_state = mcvf_pkg::S_IDLE;
                    endcase
                end
            end
            mcvf_pkg::S_SCAN: begin
                if (r_len_a[r_idx] != '0) begin
                    n_state = mcvf_pkg::S_MUL;
                end else if (idx_last) begin
                    n_state = mcvf_pkg::S_IDLE;
                end
            end
            mcvf_pkg::S_MUL: n_state = mcvf_pkg::S_DIV;
            mcvf_pkg::S_DIV: begin
                if (r_cnt == 5'(PW - 1)) n_state = mcvf_pkg::S_FIN;
            end
            mcvf_pkg::S_FIN: begin
                if ((r_op == mcvf_pkg::REQ_TICK) && !idx_last) begin
                    n_state = mcvf_pkg::S_SCAN;
                end else begin
                    n_state = mcvf_pkg::S_IDLE;
                end
            end
            mcvf_pkg::S_ALL: begin
                if (idx_last) n_state = mcvf_pkg::S_IDLE;
            end
            default: n_state = mcvf_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_len_a  = r_len_a;
        n_el_a   = r_el_a;
        n_sl_a   = r_sl_a;
        n_tl_a   = r_tl_a;
        n_op     = r_op;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_q      = r_q;
        n_neg    = r_neg;
        n_c      = r_c;
        n_len    = r_len;
        n_newlen = r_newlen;
        n_dt     = r_dt;
        n_end    = r_end;
        n_valid  = 1'b0;
        n_res    = '0;
        case (r_state)
            mcvf_pkg::S_IDLE: begin
                if (accept) begin
                    n_op     = i_req.req_type;
                    n_dt     = i_req.elapsed_ms;
                    n_newlen = req_len;
                    n_idx    = '0;
                    case (i_req.req_type)
                        mcvf_pkg::REQ_PLAY: begin
                            if (ch_ok) begin
                                n_len_a[ch_idx] = req_len;
                                if (i_req.fade_units != 10'd0) begin
                                    n_sl_a[ch_idx] = '0;
                                    n_el_a[ch_idx] = '0;
                                end
                                n_valid            = 1'b1;
                                n_res.out_channel  = i_req.channel;
                                n_res.apply_volume = (i_req.fade_units != 10'd0);
                                n_res.start_play   = 1'b1;
                                n_res.repeat_res   = i_req.loop_flag;
                                n_res.last         = 1'b1;
                            end
                        end
                        mcvf_pkg::REQ_STOP: begin
                            if (stop_interp) begin
                                n_idx = ch_idx;
                                n_c   = r_el_a[ch_idx];
                                n_len = r_len_a[ch_idx];
                            end else if (ch_ok) begin
                                n_sl_a[ch_idx]  = r_tl_a[ch_idx];
                                n_tl_a[ch_idx]  = '0;
                                n_el_a[ch_idx]  = '0;
                                n_len_a[ch_idx] = req_len;
                                if (i_req.fade_units == 10'd0) begin
                                    n_valid           = 1'b1;
                                    n_res.out_channel = i_req.channel;
                                    n_res.halt        = 1'b1;
                                    n_res.wait_end    = i_req.wait_flag;
                                    n_res.last        = 1'b1;
                                end
                            end
                        end
                        mcvf_pkg::REQ_SET_VOL: begin
                            if (ch_ok) begin
                                n_el_a[ch_idx]  = '0;
                                n_len_a[ch_idx] = req_len;
                                if (i_req.fade_units == 10'd0) begin
                                    n_valid            = 1'b1;
                                    n_res.out_channel  = i_req.channel;
                                    n_res.apply_volume = 1'b1;
                                    n_res.level        = req_vol;
                                    n_res.last         = 1'b1;
                                end else begin
                                    n_sl_a[ch_idx] = r_tl_a[ch_idx];
                                end
                                n_tl_a[ch_idx] = req_vol;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            mcvf_pkg::S_SCAN: begin
                if (r_len_a[r_idx] != '0) begin
                    n_el_a[r_idx] = el_sat;
                    n_len         = r_len_a[r_idx];
                    n_end         = (el_sat >= r_len_a[r_idx]);
                    n_c           = n_end ? r_len_a[r_idx] : el_sat;
                end else if (!idx_last) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            mcvf_pkg::S_MUL: begin
                n_neg = diff[VW];
                n_dvd = PW'((diff[VW] ? VW'(-diff) : diff[VW-1:0]) * r_c);
                n_rem = '0;
                n_q   = '0;
                n_cnt = '0;
            end
            mcvf_pkg::S_DIV: begin
                // one restoring step per cycle
                if (rem_sh >= {1'b0, r_len}) begin
                    n_rem = LW'(rem_sh - {1'b0, r_len});
                    n_q   = {r_q[VW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[LW-1:0];
                    n_q   = {r_q[VW-2:0], 1'b0};
                end
                n_dvd = {r_dvd[PW-2:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
            end
            mcvf_pkg::S_FIN: begin
                if (r_op == mcvf_pkg::REQ_TICK) begin
                    if (r_end || ((lvl == '0) && (r_tl_a[r_idx] == '0))) begin
                        n_len_a[r_idx] = '0;
                    end
                    n_valid            = 1'b1;
                    n_res.out_channel  = 3'(r_idx);
                    n_res.apply_volume = 1'b1;
                    n_res.level        = lvl;
                    n_res.halt         = (lvl == '0) && (r_tl_a[r_idx] == '0);
                    n_res.last         = !more_fading;
                    if (!idx_last) n_idx = r_idx + 1'b1;
                end else begin
                    n_sl_a[r_idx]  = lvl;
                    n_tl_a[r_idx]  = '0;
                    n_el_a[r_idx]  = '0;
                    n_len_a[r_idx] = r_newlen;
                end
            end
            mcvf_pkg::S_ALL: begin
                n_len_a[r_idx]    = '0;
                n_valid           = 1'b1;
                n_res.out_channel = 3'(r_idx);
                n_res.halt        = 1'b1;
                n_res.last        = idx_last;
                if (!idx_last) n_idx = r_idx + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mcvf_pkg::S_IDLE;
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_op    <= mcvf_pkg::REQ_PLAY;
            for (int k = 0; k < CHANNELS; k++) begin
                r_len_a[k] <= '0;
                r_el_a[k]  <= '0;
                r_sl_a[k]  <= '0;
                r_tl_a[k]  <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_idx   <= n_idx;
            r_op    <= n_op;
            r_len_a <= n_len_a;
            r_el_a  <= n_el_a;
            r_sl_a  <= n_sl_a;
            r_tl_a  <= n_tl_a;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_q      <= n_q;
        r_neg    <= n_neg;
        r_c      <= n_c;
        r_len    <= n_len;
        r_newlen <= n_newlen;
        r_dt     <= n_dt;
        r_end    <= n_end;
        r_res    <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

### hw/rtl/mcvf_checker.sv
// Port-level checks for the multichannel volume fader, bound to the top.
// Depends on mcvf_pkg and multichannel_volume_fader_defines.svh.
`include "multichannel_volume_fader_defines.svh"

module mcvf_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           start,
    input logic           busy,
    input mcvf_pkg::t_req i_req,
    input logic           o_valid,
    input mcvf_pkg::t_res o_res
);

    `MCVF_ASSERT_IMPLY(a_no_play_halt, i_clk, i_rst_n, o_valid, !(o_res.start_play && o_res.halt))
    `MCVF_ASSERT_IMPLY(a_level_range, i_clk, i_rst_n, o_valid, o_res.level <= mcvf_pkg::FULL_LEVEL)
    `MCVF_ASSERT_IMPLY(a_level_unused, i_clk, i_rst_n, o_valid && !o_res.apply_volume, o_res.level == 7'd0)
    `MCVF_ASSERT_NEXT(a_stop_all_busy, i_clk, i_rst_n, start && !busy && (i_req.req_type == mcvf_pkg::REQ_STOP_ALL), busy && !o_valid)

endmodule

bind multichannel_volume_fader mcvf_checker u_mcvf_checker (.*);
